### rtl/core/awmd_pkg.sv
// shared types, constants and register codes of the windowed motion detector
package awmd_pkg;

	// window geometry
	localparam int WINDOW  = 32;
	localparam int GROUP   = 8;
	localparam int NGROUPS = (WINDOW + GROUP - 1) / GROUP;
	localparam int PAD_W   = NGROUPS * GROUP;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int GCNT_W  = $clog2(GROUP + 1);

	// field widths
	localparam int SMP_W    = 16;
	localparam int DELTA_W  = 16;
	localparam int NOISE_W  = 18;
	localparam int REQ_W    = 6;
	localparam int PAIR_W   = 6;
	localparam int PAIR_MAX = 63;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 18;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MIN_DX  = 3'd0,
		REG_MIN_DY  = 3'd1,
		REG_MIN_DZ  = 3'd2,
		REG_MIN_CNT = 3'd3,
		REG_NOISE   = 3'd4
	} cfg_reg_t;

	// one three-axis reading
	typedef struct packed {
		logic signed [SMP_W-1:0] x;
		logic signed [SMP_W-1:0] y;
		logic signed [SMP_W-1:0] z;
	} sample_t;

	// pair match thresholds
	typedef struct packed {
		logic [DELTA_W-1:0] min_dx;
		logic [DELTA_W-1:0] min_dy;
		logic [DELTA_W-1:0] min_dz;
		logic [NOISE_W-1:0] noise;
	} thr_t;

	// per-cell control from the top level
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

### rtl/core/awmd_if.sv
// sample, result and configuration channel interfaces
interface awmd_smp_if import awmd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample_x;
	logic signed [SMP_W-1:0] sample_y;
	logic signed [SMP_W-1:0] sample_z;

	modport source (output valid, sample_x, sample_y, sample_z, input ready);
	modport sink (input valid, sample_x, sample_y, sample_z, output ready);
endinterface

interface awmd_res_if import awmd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              motion_detected;
	logic [PAIR_W-1:0] matching_pairs;

	modport source (output valid, motion_detected, matching_pairs, input ready);
	modport sink (input valid, motion_detected, matching_pairs, output ready);
endinterface

interface awmd_cfg_if import awmd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/accel_window_motion_detect.sv
// Windowed accelerometer motion detector. Accepts one three-axis word per clock
// while the output is not backed up, and returns one result word per accepted
// word, in order. A word is shifted into a row of WINDOW+1 sample slots; each of
// the WINDOW older slots compares itself with its newer neighbor and registers a
// match flag, then two count stages sum the flags and compare against the
// required count. Result valid follows the window shift at the accepting edge
// through the cell flag register, group count and result register. Up to four
// words are held in flight, so input stays ready while a result waits on the
// output until every stage is full. No clearing pass after reset. Configuration
// registers (index 0 min_delta_x, 1 min_delta_y, 2 min_delta_z, 3 min_pair_count,
// 4 noise_level) must be written through the cfg channel only while the block
// is idle; the block itself does not enforce this. Writes to other indexes
// are dropped.
module accel_window_motion_detect import awmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	awmd_smp_if.sink   smp,
	awmd_res_if.source res,
	awmd_cfg_if.sink   cfg
);

	thr_t              thr_q;
	logic [REQ_W-1:0]  req_q;
	sample_t           head_smp_q;
	logic              head_vld_q;
	sample_t           win_smp [WINDOW+1];
	logic              win_vld [WINDOW+1];
	logic [WINDOW-1:0] flags;
	logic              v0_q;
	logic              v1_q;
	logic              has_pair_s1;
	logic              en0;
	logic              en1;
	logic              pc_rdy;
	logic              accept;
	cell_ctrl_t        ctrl;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.min_dx <= '0;
			thr_q.min_dy <= '0;
			thr_q.min_dz <= '0;
			thr_q.noise  <= NOISE_W'(10);
			req_q        <= REQ_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MIN_DX:  thr_q.min_dx <= cfg.data[DELTA_W-1:0];
				REG_MIN_DY:  thr_q.min_dy <= cfg.data[DELTA_W-1:0];
				REG_MIN_DZ:  thr_q.min_dz <= cfg.data[DELTA_W-1:0];
				REG_MIN_CNT: req_q        <= cfg.data[REQ_W-1:0];
				REG_NOISE:   thr_q.noise  <= cfg.data[NOISE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables
	assign en1       = !v1_q || pc_rdy;
	assign en0       = !v0_q || en1;
	assign smp.ready = en0;
	assign accept    = smp.valid && en0;
	assign ctrl      = '{shift: accept, load: en1};

	// pending-word and flag stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q       <= 1'b0;
			v1_q       <= 1'b0;
			head_vld_q <= 1'b0;
		end else begin
			if (en0) begin
				v0_q <= smp.valid;
			end
			if (en1) begin
				v1_q <= v0_q;
			end
			if (accept) begin
				head_vld_q <= 1'b1;
			end
		end
	end

	// newest sample slot
	always_ff @(posedge clk) begin
		if (accept) begin
			head_smp_q <= '{x: smp.sample_x, y: smp.sample_y, z: smp.sample_z};
		end
		if (en1) begin
			has_pair_s1 <= win_vld[1];
		end
	end

	assign win_smp[0] = head_smp_q;
	assign win_vld[0] = head_vld_q;

	// chain of cells, oldest at the far end
	for (genvar k = 1; k <= WINDOW; k++) begin : g_cell
		awmd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.thr    (thr_q),
			.nb_smp (win_smp[k-1]),
			.nb_vld (win_vld[k-1]),
			.smp    (win_smp[k]),
			.vld    (win_vld[k]),
			.flag   (flags[k-1])
		);
	end

	// pair count and result
	awmd_count u_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (v1_q),
		.in_rdy   (pc_rdy),
		.flags    (flags),
		.has_pair (has_pair_s1),
		.req      (req_q),
		.res      (res)
	);

endmodule

### rtl/core/awmd_cell.sv
// one window slot: holds a sample, compares it with its newer neighbor
module awmd_cell import awmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  thr_t       thr,
	input  sample_t    nb_smp,
	input  logic       nb_vld,
	output sample_t    smp,
	output logic       vld,
	output logic       flag
);

	sample_t            smp_q;
	logic               vld_q;
	logic               flag_s1;
	logic [DELTA_W-1:0] dx;
	logic [DELTA_W-1:0] dy;
	logic [DELTA_W-1:0] dz;
	logic [NOISE_W-1:0] sum;
	logic               match;

	function automatic logic [DELTA_W-1:0] absdiff(
		input logic signed [SMP_W-1:0] a,
		input logic signed [SMP_W-1:0] b
	);
		logic signed [SMP_W:0] d;
		d = {a[SMP_W-1], a} - {b[SMP_W-1], b};
		return d[SMP_W] ? DELTA_W'(-d) : DELTA_W'(d);
	endfunction

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= nb_vld;
		end
	end

	// sample moves one slot older on each accepted word
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			smp_q <= nb_smp;
		end
	end

	// pair test against the newer neighbor
	always_comb begin
		dx    = absdiff(nb_smp.x, smp_q.x);
		dy    = absdiff(nb_smp.y, smp_q.y);
		dz    = absdiff(nb_smp.z, smp_q.z);
		sum   = NOISE_W'(dx) + NOISE_W'(dy) + NOISE_W'(dz);
		match = vld_q && nb_vld && (sum > thr.noise) &&
			(dx >= thr.min_dx) && (dy >= thr.min_dy) && (dz >= thr.min_dz);
	end

	// registered match flag
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			flag_s1 <= match;
		end
	end

	assign smp  = smp_q;
	assign vld  = vld_q;
	assign flag = flag_s1;

endmodule

### rtl/core/awmd_count.sv
// two-stage pair count and threshold compare feeding the result register
module awmd_count import awmd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  logic [WINDOW-1:0] flags,
	input  logic              has_pair,
	input  logic [REQ_W-1:0]  req,
	awmd_res_if.source        res
);

	logic [PAD_W-1:0]  flags_pad;
	logic [GCNT_W-1:0] gcnt_d [NGROUPS];
	logic [GCNT_W-1:0] gcnt_s2 [NGROUPS];
	logic              v2_q;
	logic              has_pair_s2;
	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  need;
	logic              det_d;
	logic [PAIR_W-1:0] pairs_d;
	logic              res_vld_q;
	logic              det_q;
	logic [PAIR_W-1:0] pairs_q;
	logic              en2;
	logic              en3;

	// stage enables
	assign en3    = !res_vld_q || res.ready;
	assign en2    = !v2_q || en3;
	assign in_rdy = en2;

	// per-group popcount
	assign flags_pad = PAD_W'(flags);
	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			gcnt_d[g] = '0;
			for (int b = 0; b < GROUP; b++) begin
				gcnt_d[g] = gcnt_d[g] + GCNT_W'(flags_pad[g*GROUP + b]);
			end
		end
	end

	// group count stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (en2) begin
			v2_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			gcnt_s2     <= gcnt_d;
			has_pair_s2 <= has_pair;
		end
	end

	// final sum and compare
	always_comb begin
		total = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			total = total + CNT_W'(gcnt_s2[g]);
		end
		need    = (32'(req) > 32'(WINDOW)) ? CNT_W'(WINDOW) : CNT_W'(req);
		det_d   = has_pair_s2 && (total >= need);
		pairs_d = (total > CNT_W'(PAIR_MAX)) ? PAIR_W'(PAIR_MAX) : PAIR_W'(total);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en3) begin
			res_vld_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			det_q   <= det_d;
			pairs_q <= pairs_d;
		end
	end

	assign res.valid           = res_vld_q;
	assign res.motion_detected = det_q;
	assign res.matching_pairs  = pairs_q;

endmodule

### rtl/core/awmd_checker.sv
// port-level checks of the motion detector, bound to the top level
module awmd_checker import awmd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              smp_valid,
	input logic              smp_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic              res_det,
	input logic [PAIR_W-1:0] res_pairs
);

	logic       in_fire;
	logic       out_fire;
	logic [2:0] open_q;
	logic [1:0] seen_q;

	assign in_fire  = smp_valid && smp_ready;
	assign out_fire = res_valid && res_ready;

	// words in flight and words seen since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			seen_q <= '0;
		end else begin
			open_q <= open_q + 3'(in_fire) - 3'(out_fire);
			if (in_fire && seen_q != 2'd2) begin
				seen_q <= seen_q + 2'd1;
			end
		end
	end

	// input stalls only when the output is backed up
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!smp_ready |-> res_valid && !res_ready)
		else $error("input stalled without output backpressure");

	// no result without an outstanding word, and no more than four in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> open_q != 3'd0 && open_q <= 3'd4)
		else $error("result count does not track accepted words");

	// a result with only one sample seen has no pairs
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seen_q == 2'd1 |-> !res_det && res_pairs == '0)
		else $error("pairs reported from a single sample");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pairs) && $stable(res_det))
		else $error("stalled result changed");

endmodule

bind accel_window_motion_detect awmd_checker u_awmd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (smp.valid),
	.smp_ready (smp.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_det   (res.motion_detected),
	.res_pairs (res.matching_pairs)
);

### tb/sv/accel_window_motion_detect_tb.sv
// self-checking testbench for the windowed accelerometer motion detector
module accel_window_motion_detect_tb;
	import awmd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// expected result of one sample word
	typedef struct packed {
		logic              motion;
		logic [PAIR_W-1:0] pairs;
	} motion_result_t;

	localparam logic [IDX_W-1:0] REG_SPARE_FIRST = IDX_W'(int'(REG_NOISE) + 1);
	localparam int               LONG_HOLD       = 100;
	localparam int               MAX_REPORTS     = 10;
	localparam int               AXIS_MAX        = 32767;
	localparam int               AXIS_MIN        = -32768;
	localparam int               DELTA_MAX       = 65535;

	// generator modes
	typedef enum int {
		GEN_NOISE,
		GEN_STEADY,
		GEN_SWING
	} gen_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	awmd_smp_if smp ();
	awmd_res_if res ();
	awmd_cfg_if cfg ();

	accel_window_motion_detect dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.res    (res),
		.cfg    (cfg)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state: threshold copy and sample window
	logic [DELTA_W-1:0] thr_dx = '0;
	logic [DELTA_W-1:0] thr_dy = '0;
	logic [DELTA_W-1:0] thr_dz = '0;
	logic [REQ_W-1:0]   thr_count = REQ_W'(1);
	logic [NOISE_W-1:0] thr_noise = NOISE_W'(10);
	sample_t            win_store [WINDOW+1];
	int unsigned        win_fill = 0;

	// stimulus and checking state
	sample_t        sample_pending [$];
	motion_result_t motion_expected [$];
	sample_t        word_on_bus;
	int             src_gap = 0;
	int             snk_gap = 0;
	bit             idle_on = 1'b0;
	int             hold_req = 0;
	int             hold_ack = 0;
	int             hold_cnt = 0;
	int             fail_count = 0;
	int             words_sent = 0;
	int             results_checked = 0;
	int             settings_run = 0;

	// generator state
	sample_t   gen_prev = '0;
	gen_mode_t gen_mode = GEN_NOISE;
	int        gen_left = 0;

	function automatic int abs_delta(logic signed [SMP_W-1:0] a, logic signed [SMP_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	// one consecutive pair against the thresholds
	function automatic bit pair_moves(sample_t older, sample_t newer);
		int dx;
		int dy;
		int dz;
		dx = abs_delta(newer.x, older.x);
		dy = abs_delta(newer.y, older.y);
		dz = abs_delta(newer.z, older.z);
		if (dx + dy + dz <= int'(thr_noise))
			return 1'b0;
		return dx >= int'(thr_dx) && dy >= int'(thr_dy) && dz >= int'(thr_dz);
	endfunction

	// shift the word into the window and count moving pairs
	function automatic motion_result_t motion_predict(sample_t s);
		int unsigned    hits;
		int unsigned    need;
		motion_result_t r;
		if (win_fill >= WINDOW + 1) begin
			for (int i = 0; i < WINDOW; i++)
				win_store[i] = win_store[i+1];
			win_fill = WINDOW;
		end
		win_store[win_fill] = s;
		win_fill++;
		hits = 0;
		for (int i = 1; i < win_fill; i++)
			if (pair_moves(win_store[i-1], win_store[i]))
				hits++;
		need = (thr_count > WINDOW) ? WINDOW : thr_count;
		r.motion = (win_fill >= 2) && (hits >= need);
		r.pairs = (hits > PAIR_MAX) ? PAIR_W'(PAIR_MAX) : PAIR_W'(hits);
		return r;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// sample driver
	always @(posedge clk) begin
		sample_t nxt;
		bit      offer;
		if (smp.valid && smp.ready) begin
			motion_expected.push_back(motion_predict(word_on_bus));
			words_sent++;
		end
		if (!smp.valid || smp.ready) begin
			offer = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
			end else if (sample_pending.size() > 0) begin
				nxt = sample_pending.pop_front();
				offer = 1'b1;
				if (idle_on && $urandom_range(0, 6) == 0)
					src_gap = $urandom_range(1, 18);
			end
			smp.valid <= offer;
			if (offer) begin
				smp.sample_x <= nxt.x;
				smp.sample_y <= nxt.y;
				smp.sample_z <= nxt.z;
				word_on_bus = nxt;
			end
		end
	end

	// long output stall, counted on its own
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cnt <= LONG_HOLD;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// result monitor and checker
	always @(posedge clk) begin
		motion_result_t got;
		motion_result_t want;
		if (res.valid && res.ready) begin
			got.motion = res.motion_detected;
			got.pairs = res.matching_pairs;
			results_checked++;
			if (motion_expected.size() == 0) begin
				note_failure($sformatf("unexpected result motion=%0b pairs=%0d",
					got.motion, got.pairs));
			end else begin
				want = motion_expected.pop_front();
				if (got.motion !== want.motion || got.pairs !== want.pairs)
					note_failure($sformatf(
						"result %0d: motion exp %0b got %0b, pairs exp %0d got %0d",
						results_checked, want.motion, got.motion, want.pairs, got.pairs));
			end
		end
		if (hold_cnt > 0) begin
			res.ready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
			if (idle_on && $urandom_range(0, 6) == 0)
				snk_gap = $urandom_range(1, 18);
		end
	end

	// one register write over the cfg channel, mirrored into the predictor
	task automatic reg_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_MIN_DX:  thr_dx = data[DELTA_W-1:0];
			REG_MIN_DY:  thr_dy = data[DELTA_W-1:0];
			REG_MIN_DZ:  thr_dz = data[DELTA_W-1:0];
			REG_MIN_CNT: thr_count = data[REQ_W-1:0];
			REG_NOISE:   thr_noise = data[NOISE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [DATA_W-1:0] dx, logic [DATA_W-1:0] dy,
		logic [DATA_W-1:0] dz, logic [DATA_W-1:0] count, logic [DATA_W-1:0] noise);
		reg_write(REG_MIN_DX, dx);
		reg_write(REG_MIN_DY, dy);
		reg_write(REG_MIN_DZ, dz);
		reg_write(REG_MIN_CNT, count);
		reg_write(REG_NOISE, noise);
		// writes to unused indexes must leave everything alone
		if ($urandom_range(0, 2) == 0)
			reg_write(IDX_W'($urandom_range(REG_SPARE_FIRST, (1 << IDX_W) - 1)),
				DATA_W'($urandom));
		settings_run++;
	endtask

	// wait for all queued words to go in and all results to come back
	task automatic drain();
		do
			@(negedge clk);
		while (sample_pending.size() != 0 || smp.valid || motion_expected.size() != 0);
	endtask

	task automatic queue_word(int x, int y, int z);
		sample_t s;
		s.x = SMP_W'(x);
		s.y = SMP_W'(y);
		s.z = SMP_W'(z);
		sample_pending.push_back(s);
		gen_prev = s;
	endtask

	// step one axis by roughly the needed delta, staying in range
	function automatic int axis_step(int prev, int lo);
		int d;
		int up_room;
		int dn_room;
		case ($urandom_range(0, 4))
			0: d = lo;
			1: d = (lo > 0) ? lo - 1 : 0;
			2: d = lo + $urandom_range(0, 255);
			default: d = $urandom_range(lo, DELTA_MAX);
		endcase
		up_room = AXIS_MAX - prev;
		dn_room = prev - AXIS_MIN;
		if (d <= up_room && (d > dn_room || $urandom_range(0, 1) == 1))
			return prev + d;
		if (d <= dn_room)
			return prev - d;
		return (up_room > dn_room) ? AXIS_MAX : AXIS_MIN;
	endfunction

	function automatic int jitter(int prev);
		int v;
		v = prev + $urandom_range(0, 6) - 3;
		if (v > AXIS_MAX)
			v = AXIS_MAX;
		if (v < AXIS_MIN)
			v = AXIS_MIN;
		return v;
	endfunction

	// runs of moving, steady and random words
	task automatic queue_random(int n);
		int floor_lo;
		int lx;
		int ly;
		int lz;
		floor_lo = (int'(thr_noise) + 3) / 3;
		lx = (int'(thr_dx) > floor_lo) ? int'(thr_dx) : floor_lo;
		ly = (int'(thr_dy) > floor_lo) ? int'(thr_dy) : floor_lo;
		lz = (int'(thr_dz) > floor_lo) ? int'(thr_dz) : floor_lo;
		if (lx > DELTA_MAX)
			lx = DELTA_MAX;
		if (ly > DELTA_MAX)
			ly = DELTA_MAX;
		if (lz > DELTA_MAX)
			lz = DELTA_MAX;
		repeat (n) begin
			if (gen_left == 0) begin
				case ($urandom_range(0, 9))
					0, 1:    gen_mode = GEN_NOISE;
					2:       gen_mode = GEN_STEADY;
					default: gen_mode = GEN_SWING;
				endcase
				gen_left = $urandom_range(1, 45);
			end
			gen_left--;
			case (gen_mode)
				GEN_SWING:
					queue_word(axis_step(int'(gen_prev.x), lx), axis_step(int'(gen_prev.y), ly),
						axis_step(int'(gen_prev.z), lz));
				GEN_STEADY:
					queue_word(jitter(int'(gen_prev.x)), jitter(int'(gen_prev.y)),
						jitter(int'(gen_prev.z)));
				default:
					queue_word(int'($signed(SMP_W'($urandom))), int'($signed(SMP_W'($urandom))),
						int'($signed(SMP_W'($urandom))));
			endcase
		end
	endtask

	task automatic run_random(int n);
		@(negedge clk);
		queue_random(n);
		drain();
	endtask

	function automatic logic [DATA_W-1:0] pick_delta();
		case ($urandom_range(0, 6))
			0:       return '0;
			1:       return DATA_W'(DELTA_MAX);
			2:       return DATA_W'($urandom_range(0, 64));
			3, 4:    return DATA_W'($urandom_range(0, 2000));
			5:       return DATA_W'($urandom_range(0, DELTA_MAX));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_count();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return DATA_W'(1);
			2:       return DATA_W'(WINDOW);
			3:       return DATA_W'(WINDOW + 1);
			4:       return DATA_W'(PAIR_MAX);
			5:       return DATA_W'($urandom_range(0, PAIR_MAX));
			default: return DATA_W'($urandom_range(0, 8));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_noise();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return {DATA_W{1'b1}};
			2, 3:    return DATA_W'($urandom_range(0, 30));
			4:       return DATA_W'($urandom_range(0, 3000));
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// main sequence
	initial begin
		smp.valid = 1'b0;
		smp.sample_x = '0;
		smp.sample_y = '0;
		smp.sample_z = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed words under the reset thresholds
		idle_on = 1'b1;
		@(negedge clk);
		queue_word(0, 0, 0);             // lone sample, no pair yet
		queue_word(0, 0, 0);             // no change
		queue_word(10, 0, 0);            // sum equals noise level
		queue_word(21, 0, 0);            // sum just above noise level
		queue_word(AXIS_MAX, AXIS_MAX, AXIS_MAX);
		queue_word(AXIS_MIN, AXIS_MIN, AXIS_MIN);
		queue_word(AXIS_MAX, AXIS_MIN, AXIS_MAX);
		queue_word(AXIS_MIN, AXIS_MAX, AXIS_MIN);
		queue_word(AXIS_MIN, AXIS_MAX, AXIS_MIN);
		queue_word(-1, -1, -1);
		queue_word(0, 0, 0);
		queue_word(4, 4, 3);
		queue_word(int'($signed(16'h5555)), int'($signed(16'haaaa)), int'($signed(16'h5555)));
		queue_word(int'($signed(16'haaaa)), int'($signed(16'h5555)), int'($signed(16'haaaa)));
		queue_word(1, 2, 3);
		queue_word(-4, 6, -9);
		queue_word(0, 0, 0);
		drain();

		// thresholds that can never be met
		apply_settings(DATA_W'(DELTA_MAX), DATA_W'(DELTA_MAX), DATA_W'(DELTA_MAX),
			DATA_W'(PAIR_MAX), {DATA_W{1'b1}});
		run_random(60);

		// everything open, zero required pairs
		apply_settings('0, '0, '0, '0, '0);
		run_random(60);

		// full window needed, required count above window size
		apply_settings(DATA_W'(1), DATA_W'(1), DATA_W'(1), DATA_W'(WINDOW + 1), DATA_W'(5));
		@(negedge clk);
		gen_mode = GEN_SWING;
		gen_left = 2 * WINDOW;
		queue_random(70);
		drain();

		// random settings
		repeat (11) begin
			idle_on = ($urandom_range(0, 3) != 0);
			apply_settings(pick_delta(), pick_delta(), pick_delta(), pick_count(), pick_noise());
			run_random(70);
		end

		// long output stall while words keep coming
		idle_on = 1'b0;
		apply_settings(DATA_W'($urandom_range(0, 40)), '0, DATA_W'($urandom_range(0, 40)),
			pick_count(), DATA_W'($urandom_range(0, 30)));
		@(negedge clk);
		hold_req = hold_req + 1;
		queue_random(50);
		drain();

		// closing stretch without idling
		apply_settings(pick_delta(), pick_delta(), pick_delta(), pick_count(), pick_noise());
		run_random(80);

		repeat (8) @(posedge clk);
		if (motion_expected.size() != 0)
			note_failure($sformatf("%0d results never arrived", motion_expected.size()));
		$display("checked %0d results from %0d sample words", results_checked, words_sent);
		$display("under %0d threshold settings, with a long output stall", settings_run + 1);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#5ms;
		$display("timeout with %0d results still pending", motion_expected.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
